// ===== rtl/core/hse_pkg.sv =====
// hse_pkg: shared constants and types of the heap sort engine
// depends on nothing; used by hse_sort, heap_sort_engine and tb_heap_sort_engine
`default_nettype none

package hse_pkg;

    // store depth and derived widths
    localparam int CAPACITY = 32;
    localparam int DW = 32;
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = AW + 1;

    typedef logic signed [DW-1:0] t_data;

    // one cycle of requests to the heap store
    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        t_data         wdata;
        logic [AW-1:0] raddr_a;
        logic [AW-1:0] raddr_b;
    } t_ram_req;

endpackage

`default_nettype wire

// ===== rtl/core/hse_ram.sv =====
// hse_ram: generic store, one write port, two read ports with registered data
// depends on nothing
`default_nettype none

module hse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ===== rtl/core/hse_sort.sv =====
// hse_sort: heap build and extraction sequencer around one signed compare unit
// depends on hse_pkg; drives the heap store through a t_ram_req
`default_nettype none

module hse_sort (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [hse_pkg::CW-1:0] i_len,
    input  wire hse_pkg::t_data         i_rdata_a,
    input  wire hse_pkg::t_data         i_rdata_b,
    output hse_pkg::t_ram_req           o_req,
    output logic                        o_done
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_FETCH   = 7'b0000010,
        S_LATCH   = 7'b0000100,
        S_DESC    = 7'b0001000,
        S_CMP     = 7'b0010000,
        S_SWAP_RD = 7'b0100000,
        S_SWAP_WR = 7'b1000000
    } t_state;

    t_state                  r_state, n_state;
    logic                    r_build, n_build;
    logic                    r_done, n_done;
    logic [hse_pkg::CW-1:0]  r_len, n_len;
    logic [hse_pkg::AW-1:0]  r_start, n_start;
    logic [hse_pkg::AW-1:0]  r_p, n_p;
    hse_pkg::t_data          r_val, n_val;

    logic [hse_pkg::LW-1:0]  w_left;
    logic [hse_pkg::LW-1:0]  w_right;
    logic [hse_pkg::LW-1:0]  w_len_ext;
    logic                    w_has_left;
    logic                    w_has_right;
    logic                    w_right_big;
    logic                    w_move;
    logic                    w_finish;
    hse_pkg::t_data          w_child;
    logic [hse_pkg::AW-1:0]  w_child_idx;
    logic [hse_pkg::AW-1:0]  w_last;

    // children of the hole
    assign w_left      = {r_p, 1'b1};
    assign w_right     = w_left + hse_pkg::LW'(1);
    assign w_len_ext   = hse_pkg::LW'(r_len);
    assign w_has_left  = w_left < w_len_ext;
    assign w_has_right = w_right < w_len_ext;

    // the shared compare unit
    assign w_right_big = w_has_right && (i_rdata_b > i_rdata_a);
    assign w_child     = w_right_big ? i_rdata_b : i_rdata_a;
    assign w_child_idx = w_right_big ? w_right[hse_pkg::AW-1:0] : w_left[hse_pkg::AW-1:0];
    assign w_move      = w_child > r_val;

    assign w_last = hse_pkg::AW'(r_len - hse_pkg::CW'(1));

    always_comb begin
        n_state       = r_state;
        n_build       = r_build;
        n_done        = 1'b0;
        n_len         = r_len;
        n_start       = r_start;
        n_p           = r_p;
        n_val         = r_val;
        w_finish      = 1'b0;
        o_req.we      = 1'b0;
        o_req.waddr   = r_p;
        o_req.wdata   = r_val;
        o_req.raddr_a = r_p;
        o_req.raddr_b = w_right[hse_pkg::AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_len   = i_len;
                    n_build = 1'b1;
                    if (i_len > hse_pkg::CW'(1)) begin
                        n_start = hse_pkg::AW'((i_len >> 1) - hse_pkg::CW'(1));
                        n_p     = hse_pkg::AW'((i_len >> 1) - hse_pkg::CW'(1));
                        n_state = S_FETCH;
                    end else begin
                        n_done = 1'b1;
                    end
                end
            end
            S_FETCH: begin
                o_req.raddr_a = r_p;
                n_state       = S_LATCH;
            end
            S_LATCH: begin
                n_val   = i_rdata_a;
                n_state = S_DESC;
            end
            S_DESC: begin
                o_req.raddr_a = w_left[hse_pkg::AW-1:0];
                o_req.raddr_b = w_right[hse_pkg::AW-1:0];
                if (w_has_left) begin
                    n_state = S_CMP;
                end else begin
                    o_req.we    = 1'b1;
                    o_req.waddr = r_p;
                    o_req.wdata = r_val;
                    w_finish    = 1'b1;
                end
            end
            S_CMP: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_p;
                if (w_move) begin
                    o_req.wdata = w_child;
                    n_p         = w_child_idx;
                    n_state     = S_DESC;
                end else begin
                    o_req.wdata = r_val;
                    w_finish    = 1'b1;
                end
            end
            S_SWAP_RD: begin
                o_req.raddr_a = '0;
                o_req.raddr_b = w_last;
                n_state       = S_SWAP_WR;
            end
            S_SWAP_WR: begin
                o_req.we    = 1'b1;
                o_req.waddr = w_last;
                o_req.wdata = i_rdata_a;
                n_val       = i_rdata_b;
                n_len       = r_len - hse_pkg::CW'(1);
                n_p         = '0;
                n_state     = S_DESC;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // sift-down ended: next build node, next extraction or done
        if (w_finish) begin
            if (r_build) begin
                if (r_start == '0) begin
                    n_build = 1'b0;
                    n_state = S_SWAP_RD;
                end else begin
                    n_start = r_start - hse_pkg::AW'(1);
                    n_p     = r_start - hse_pkg::AW'(1);
                    n_state = S_FETCH;
                end
            end else if (r_len > hse_pkg::CW'(1)) begin
                n_state = S_SWAP_RD;
            end else begin
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_build <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_build <= n_build;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_start <= n_start;
        r_p     <= n_p;
        r_val   <= n_val;
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

// ===== rtl/core/heap_sort_engine.sv =====
// heap_sort_engine: top level, load and emit control, output register, store
// depends on hse_pkg, hse_ram and hse_sort
`default_nettype none

// Collects signed 32-bit values, one per input transfer, into a 32-entry
// store until a transfer with tlast high arrives; that transfer is part of
// the set. Values beyond 32 are dropped and every result of that set then
// carries tuser high. The set is heap sorted in place and returned in
// ascending signed order, one output transfer per stored value, tlast on the
// last one. Loading takes one transfer per cycle while tvalid is high. After
// tlast the input is not ready until the last result is in the output
// register. Each sift-down level of the sort is one store read and one
// compare-and-write, through the single shared compare unit and the
// registered store read. Each result is read from the store and then
// loaded into the output register, which waits while the consumer stalls.
// The output register lets the next set start loading while the last
// result still waits.

module heap_sort_engine (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input stream
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic signed [31:0] i_s_tdata,   // [31:0] value
    input  wire logic               i_s_tlast,   // end_of_set
    // output stream
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic signed [31:0]      o_m_tdata,   // [31:0] sorted_value
    output logic                    o_m_tlast,   // final_res
    output logic                    o_m_tuser    // [0] overflow
);

    typedef enum logic [3:0] {
        ST_LOAD    = 4'b0001,
        ST_SORT    = 4'b0010,
        ST_EMIT_RD = 4'b0100,
        ST_EMIT_LD = 4'b1000
    } t_state;

    t_state                  r_state, n_state;
    logic [hse_pkg::CW-1:0]  r_count, n_count;   // values stored in this set
    logic                    r_drop, n_drop;     // a value of this set was dropped
    logic [hse_pkg::AW-1:0]  r_k, n_k;           // next result index
    logic                    r_ovalid;
    hse_pkg::t_data          r_odata;
    logic                    r_olast;
    logic                    r_ouser;

    logic                    w_in_xfer;
    logic                    w_full;
    logic [hse_pkg::CW-1:0]  w_len;
    logic                    w_slot_free;
    logic                    w_last_k;
    logic                    w_emit_load;
    logic                    w_sort_start;
    logic                    w_sort_done;
    hse_pkg::t_ram_req       w_sort_req;
    hse_pkg::t_ram_req       w_req;
    hse_pkg::t_data          w_rdata_a;
    hse_pkg::t_data          w_rdata_b;

    assign o_s_tready = (r_state == ST_LOAD);
    assign w_in_xfer  = i_s_tvalid && o_s_tready;
    assign w_full     = (r_count == hse_pkg::CW'(hse_pkg::CAPACITY));
    // set length including the closing transfer, unless it is dropped
    assign w_len      = w_full ? r_count : (r_count + hse_pkg::CW'(1));

    assign w_sort_start = w_in_xfer && i_s_tlast;

    // output register can take a result now or when the waiting one leaves
    assign w_slot_free = !r_ovalid || i_m_tready;
    assign w_last_k    = (hse_pkg::CW'(r_k) + hse_pkg::CW'(1)) == r_count;
    assign w_emit_load = (r_state == ST_EMIT_LD) && w_slot_free;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_drop  = r_drop;
        n_k     = r_k;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_xfer) begin
                    n_count = w_len;
                    n_drop  = r_drop || w_full;
                    n_k     = '0;
                    if (i_s_tlast) begin
                        n_state = ST_SORT;
                    end
                end
            end
            ST_SORT: begin
                if (w_sort_done) begin
                    n_state = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (w_slot_free) begin
                    if (w_last_k) begin
                        // set done; the next set may load behind the last result
                        n_count = '0;
                        n_drop  = 1'b0;
                        n_k     = '0;
                        n_state = ST_LOAD;
                    end else begin
                        n_k     = r_k + hse_pkg::AW'(1);
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // store port: sorter owns it while sorting, load/emit otherwise
    always_comb begin
        if (r_state == ST_SORT) begin
            w_req = w_sort_req;
        end else begin
            w_req.we      = w_in_xfer && !w_full;
            w_req.waddr   = r_count[hse_pkg::AW-1:0];
            w_req.wdata   = i_s_tdata;
            w_req.raddr_a = r_k;
            w_req.raddr_b = r_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_count  <= '0;
            r_drop   <= 1'b0;
            r_k      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_drop  <= n_drop;
            r_k     <= n_k;
            if (w_emit_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_emit_load) begin
            r_odata <= w_rdata_a;
            r_olast <= w_last_k;
            r_ouser <= r_drop;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_ouser;

    hse_ram #(
        .WIDTH (hse_pkg::DW),
        .DEPTH (hse_pkg::CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_req.we),
        .i_waddr   (w_req.waddr),
        .i_wdata   (w_req.wdata),
        .i_raddr_a (w_req.raddr_a),
        .i_raddr_b (w_req.raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    hse_sort u_sort (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_sort_start),
        .i_len     (w_len),
        .i_rdata_a (w_rdata_a),
        .i_rdata_b (w_rdata_b),
        .o_req     (w_sort_req),
        .o_done    (w_sort_done)
    );

endmodule

`default_nettype wire

// ===== rtl/core/hse_chk.sv =====
// hse_chk: port-level checks of heap_sort_engine, attached by bind
// depends on heap_sort_engine port list
`default_nettype none

module hse_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_s_tvalid,
    input wire logic               o_s_tready,
    input wire logic               i_s_tlast,
    input wire logic               o_m_tvalid,
    input wire logic               i_m_tready,
    input wire logic signed [31:0] o_m_tdata,
    input wire logic               o_m_tlast,
    input wire logic               o_m_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser)))
        else $error("stalled result changed");

    // closing transfer starts the sort, so the input drops ready
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> !o_s_tready)
        else $error("input ready right after end of set");

    // results of one set come out in ascending signed order
    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) |=>
            (!o_m_tvalid || (o_m_tdata >= $past(o_m_tdata))))
        else $error("results out of order");

    // overflow flag is the same on every result of a set
    a_ovf_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) |=>
            (!o_m_tvalid || (o_m_tuser == $past(o_m_tuser))))
        else $error("overflow flag changed within a set");

endmodule

bind heap_sort_engine hse_chk u_hse_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire

// ===== test/tb_heap_sort_engine.sv =====
// tb_heap_sort_engine: self-checking testbench of the heap sort engine
// depends on hse_pkg and heap_sort_engine; a directed table, then random sets
// checked against a sorting predictor, with random idling on both streams
`default_nettype none

module tb_heap_sort_engine;
    timeunit 1ns;
    timeprecision 1ps;

    localparam hse_pkg::t_data VAL_MAX = 32'sh7FFF_FFFF;
    localparam hse_pkg::t_data VAL_MIN = 32'sh8000_0000;
    localparam hse_pkg::t_data VAL_NEG1 = 32'shFFFF_FFFF;
    localparam int RANDOM_ITEMS = 180;
    localparam int IDLE_PCT = 21;
    localparam int DRAIN_CYCLES = 40;
    localparam int NUM_ROWS = 22;

    // one expected output transfer
    typedef struct {
        hse_pkg::t_data value;
        logic           final_res;
        logic           overflow;
    } t_sorted;

    // one row of the directed table; typed rows are single-value sets
    // whose only result is the value itself, last and without overflow
    typedef struct {
        hse_pkg::t_data value;
        logic           last;
        bit             typed;
        hse_pkg::t_data exp_value;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic               o_s_tready;
    logic signed [31:0] i_s_tdata = '0;   // [31:0] value
    logic               i_s_tlast = 1'b0; // end_of_set
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic signed [31:0] o_m_tdata;        // [31:0] sorted_value
    logic               o_m_tlast;        // final_res
    logic               o_m_tuser;        // [0] overflow

    // predictor state: the current set kept in ascending order
    hse_pkg::t_data set_sorted[$];
    bit             set_dropped = 1'b0;
    // results still owed by the block, oldest first
    t_sorted        sorted_due[$];

    bit             calm = 1'b0;    // no idling on either side while set
    hse_pkg::t_data prev_value = '0;
    int unsigned    err_cnt = 0;
    int unsigned    n_sent = 0;
    int unsigned    n_sets = 0;
    int unsigned    n_sets_dropped = 0;
    int unsigned    n_checked = 0;

    t_row directed_rows[NUM_ROWS] = '{
        // single-value sets right after reset: extremes come straight back
        '{VAL_MAX,           1'b1, 1'b1, VAL_MAX},
        '{VAL_MIN,           1'b1, 1'b1, VAL_MIN},
        '{32'sd0,            1'b1, 1'b1, 32'sd0},
        '{VAL_NEG1,          1'b1, 1'b1, VAL_NEG1},
        // small mixed-sign set
        '{32'sd3,            1'b0, 1'b0, '0},
        '{-32'sd3,           1'b0, 1'b0, '0},
        '{32'sd0,            1'b1, 1'b0, '0},
        // both extremes together with a duplicate pair
        '{VAL_MAX,           1'b0, 1'b0, '0},
        '{VAL_MIN,           1'b0, 1'b0, '0},
        '{32'sd5,            1'b0, 1'b0, '0},
        '{32'sd5,            1'b0, 1'b0, '0},
        '{VAL_NEG1,          1'b1, 1'b0, '0},
        // already ascending
        '{32'sd1,            1'b0, 1'b0, '0},
        '{32'sd2,            1'b0, 1'b0, '0},
        '{32'sd3,            1'b0, 1'b0, '0},
        '{32'sd4,            1'b0, 1'b0, '0},
        '{32'sd5,            1'b1, 1'b0, '0},
        // alternating bit patterns and values next to the extremes
        '{32'sh5555_5555,    1'b0, 1'b0, '0},
        '{32'shAAAA_AAAA,    1'b0, 1'b0, '0},
        '{32'sd1,            1'b0, 1'b0, '0},
        '{32'sh8000_0001,    1'b0, 1'b0, '0},
        '{32'sh7FFF_FFFE,    1'b1, 1'b0, '0}
    };

    heap_sort_engine i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // hard stop well beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // add one accepted value to the current set; on the end of a set,
    // queue the whole set in ascending signed order
    function automatic void predict_sorted(hse_pkg::t_data v, logic last);
        int unsigned pos;
        t_sorted     item;
        if (set_sorted.size() < hse_pkg::CAPACITY) begin
            pos = 0;
            while (pos < set_sorted.size() && set_sorted[pos] <= v)
                pos++;
            set_sorted.insert(pos, v);
        end else begin
            // store full: value dropped, even the one closing the set
            set_dropped = 1'b1;
        end
        if (last) begin
            foreach (set_sorted[k]) begin
                item.value = set_sorted[k];
                item.final_res = (k == set_sorted.size() - 1);
                item.overflow = set_dropped;
                sorted_due.push_back(item);
            end
            n_sets++;
            if (set_dropped)
                n_sets_dropped++;
            set_sorted.delete();
            set_dropped = 1'b0;
        end
    endfunction

    // value mix: full random, extremes, a narrow band around zero, repeats, random negatives
    function automatic hse_pkg::t_data pick_value();
        case ($urandom_range(9))
            0, 1, 2: return hse_pkg::t_data'($urandom);
            3: begin
                case ($urandom_range(3))
                    0: return VAL_MAX;
                    1: return VAL_MIN;
                    2: return 32'sd0;
                    default: return VAL_NEG1;
                endcase
            end
            4, 5, 6: return hse_pkg::t_data'(int'($urandom_range(20)) - 10);
            7: return prev_value;
            default: return hse_pkg::t_data'({1'b1, 31'($urandom)});
        endcase
    endfunction

    // drive one value and hold it until the transfer completes;
    // returns in the time step of the accepting edge
    task automatic push_element(input hse_pkg::t_data v, input logic last);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= v;
        i_s_tlast <= last;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        prev_value = v;
        n_sent++;
    endtask

    // hold the input back until every owed result has come out
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sorted_due.size() != 0)
            @(posedge i_clk);
    endtask

    // output side: check each transfer, then pick the next ready level
    always @(posedge i_clk) begin
        t_sorted want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (sorted_due.size() == 0) begin
                $error("unexpected output transfer: sorted_value %0d", o_m_tdata);
                err_cnt++;
            end else begin
                want = sorted_due.pop_front();
                n_checked++;
                if (o_m_tdata !== want.value) begin
                    $error("sorted_value: expected %0d, got %0d", want.value, o_m_tdata);
                    err_cnt++;
                end
                if (o_m_tlast !== want.final_res) begin
                    $error("final_res: expected %0b, got %0b", want.final_res, o_m_tlast);
                    err_cnt++;
                end
                if (o_m_tuser !== want.overflow) begin
                    $error("overflow: expected %0b, got %0b", want.overflow, o_m_tuser);
                    err_cnt++;
                end
            end
        end
        i_m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    initial begin
        t_sorted        item;
        hse_pkg::t_data v;
        int unsigned    set_idx;
        int unsigned    set_len;
        int unsigned    n_random;

        // reset held at start, released on a rising edge
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (directed_rows[r]) begin
            push_element(directed_rows[r].value, directed_rows[r].last);
            if (directed_rows[r].typed) begin
                item.value = directed_rows[r].exp_value;
                item.final_res = 1'b1;
                item.overflow = 1'b0;
                sorted_due.push_back(item);
                n_sets++;
            end else begin
                predict_sorted(directed_rows[r].value, directed_rows[r].last);
            end
        end

        // let the engine go fully quiet before the random part
        wait_drained();

        // random sets: first an exactly full set, then one whose closing
        // value is dropped; afterwards mostly short sets, some past capacity
        set_idx = 0;
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            if (set_idx == 0)
                set_len = hse_pkg::CAPACITY;
            else if (set_idx == 1)
                set_len = hse_pkg::CAPACITY + 1;
            else if ($urandom_range(99) < 15)
                set_len = $urandom_range(hse_pkg::CAPACITY + 8, 9);
            else
                set_len = $urandom_range(8, 1);
            // a long stretch of sets with no idling on either side
            calm = (set_idx >= 6 && set_idx < 16);
            if (set_idx == 10)
                wait_drained();
            for (int unsigned k = 0; k < set_len; k++) begin
                v = pick_value();
                push_element(v, k == set_len - 1);
                predict_sorted(v, k == set_len - 1);
                n_random++;
            end
            set_idx++;
        end
        calm = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d input transfers in %0d sets, %0d of them past capacity",
                 n_sent, n_sets, n_sets_dropped);
        $display("checked %0d sorted output transfers", n_checked);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
